// ----- hw/rtl/scac_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scac_pkg: shared types and constants of the seam cost accumulator
// Widths, fixed-point constants, register indexes and the per-pixel control
// record that travels down the pipeline.
// ----------------------------------------------------------------------------
package scac_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = 13;
	localparam int LEN_W      = (COL_W + 1 > ROW_W) ? COL_W + 1 : ROW_W;
	localparam int COST_W     = 32;
	localparam int ENERGY_W   = 24;
	localparam int MOVE_W     = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	typedef logic [COL_W-1:0]    col_t;
	typedef logic [ROW_W-1:0]    row_len_t;
	typedef logic [LEN_W-1:0]    len_t;
	typedef logic [COST_W-1:0]   cost_t;
	typedef logic [ENERGY_W-1:0] energy_t;
	typedef logic [MOVE_W-1:0]   move_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_WIDTH = 1'b0,
		REG_MOVE_COST = 1'b1
	} cfg_reg_t;

	localparam row_len_t ROW_WIDTH_RESET = 13'd1024;
	localparam move_t    MOVE_COST_RESET = 16'd256;

	// Q.8 constants: 1.0 and 255.0.
	localparam cost_t START_COST = 32'd256;
	localparam cost_t MID_LOW    = 32'd256;
	localparam cost_t MID_HIGH   = 32'd65280;
	localparam cost_t COST_MAX   = 32'hFFFF_FFFF;

	typedef struct packed {
		col_t col;
		logic last;
		logic has_left;
		logic has_right;
		logic first_row;
	} pix_ctrl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/scac_stream_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scac_stream_if: valid/ready channels of the seam cost accumulator
// One interface for incoming pixel energies, one for outgoing seam costs.
// ----------------------------------------------------------------------------
interface scac_pixel_if;
	logic              valid;
	logic              ready;
	scac_pkg::energy_t energy;
	logic              start_of_frame;

	modport source(output valid, energy, start_of_frame, input ready);
	modport sink(input valid, energy, start_of_frame, output ready);
endinterface

interface scac_result_if;
	logic            valid;
	logic            ready;
	scac_pkg::cost_t cum_cost;
	logic            end_of_row;

	modport source(output valid, cum_cost, end_of_row, input ready);
	modport sink(input valid, cum_cost, end_of_row, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/scac_line_buffer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scac_line_buffer: cost line buffer of the row above
// One write port, two registered read ports. A write at the same edge as a
// read of the same entry is forwarded into the read data.
// ----------------------------------------------------------------------------
module scac_line_buffer (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   wr_en,
	input  wire scac_pkg::col_t   wr_addr,
	input  wire scac_pkg::cost_t  wr_data,
	input  wire                   rd_en,
	input  wire scac_pkg::col_t   rd_addr_a,
	input  wire scac_pkg::col_t   rd_addr_b,
	output scac_pkg::cost_t       rd_data_a,
	output scac_pkg::cost_t       rd_data_b
);

	scac_pkg::cost_t mem [scac_pkg::MAX_WIDTH];
	scac_pkg::cost_t mem_a_q;
	scac_pkg::cost_t mem_b_q;
	scac_pkg::cost_t fwd_q;
	logic            hit_a_q;
	logic            hit_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_a_q <= mem[rd_addr_a];
			mem_b_q <= mem[rd_addr_b];
			fwd_q   <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_a_q <= 1'b0;
			hit_b_q <= 1'b0;
		end else if (rd_en) begin
			hit_a_q <= wr_en && (wr_addr == rd_addr_a);
			hit_b_q <= wr_en && (wr_addr == rd_addr_b);
		end
	end

	assign rd_data_a = hit_a_q ? fwd_q : mem_a_q;
	assign rd_data_b = hit_b_q ? fwd_q : mem_b_q;

endmodule
`default_nettype wire

// ----- hw/rtl/scac_column_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scac_column_ctrl: column and row tracking
// Derives the column, edge flags and first-row flag of the offered pixel and
// advances the column count on each accepted request.
// ----------------------------------------------------------------------------
module scac_column_ctrl (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire scac_pkg::row_len_t  row_width,
	input  wire                      start_of_frame,
	input  wire                      accept,
	output scac_pkg::pix_ctrl_t      ctrl
);

	localparam scac_pkg::len_t MAX_LEN = scac_pkg::LEN_W'(scac_pkg::MAX_WIDTH);
	localparam scac_pkg::len_t ONE_LEN = scac_pkg::LEN_W'(1);

	scac_pkg::col_t column_q;
	logic           first_row_q;
	scac_pkg::len_t row_len;
	scac_pkg::len_t width_eff;
	scac_pkg::col_t col;

	always_comb begin
		row_len = scac_pkg::LEN_W'(row_width);
		priority if (row_len == '0) begin
			width_eff = ONE_LEN;
		end else if (row_len > MAX_LEN) begin
			width_eff = MAX_LEN;
		end else begin
			width_eff = row_len;
		end
		col            = start_of_frame ? '0 : column_q;
		ctrl.col       = col;
		ctrl.last      = (scac_pkg::LEN_W'(col) + ONE_LEN) >= width_eff;
		ctrl.has_left  = (col != '0);
		ctrl.has_right = !ctrl.last;
		ctrl.first_row = start_of_frame || first_row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			first_row_q <= 1'b1;
		end else if (accept) begin
			if (ctrl.last) begin
				column_q    <= '0;
				first_row_q <= 1'b0;
			end else begin
				column_q    <= col + scac_pkg::COL_W'(1);
				first_row_q <= ctrl.first_row;
			end
		end
	end

	ap_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ctrl.last) |=> (column_q == '0 && !first_row_q))
		else $error("column count did not wrap after the last pixel of a row");

	ap_col_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !ctrl.last) |=> (column_q == $past(col) + scac_pkg::COL_W'(1)))
		else $error("column count did not step by one");

	ap_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(scac_pkg::LEN_W'(column_q) < width_eff) || (row_len == '0) || !first_row_q
		|| (scac_pkg::LEN_W'(column_q) < MAX_LEN))
		else $error("column count beyond the line buffer");

endmodule
`default_nettype wire

// ----- hw/rtl/scac_cost_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scac_cost_unit: neighbor minimum and cost arithmetic
// Stage one picks the least in-image neighbor above and keeps the up-left and
// up costs for the next pixel. Stage two adds the energy, saturates and
// subtracts the move cost from mid-range sums; first-row pixels get the start cost.
// ----------------------------------------------------------------------------
module scac_cost_unit (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      advance,
	input  wire                      valid_s1,
	input  wire scac_pkg::pix_ctrl_t ctrl_s1,
	input  wire scac_pkg::energy_t   energy_s1,
	input  wire scac_pkg::cost_t     up_read,
	input  wire scac_pkg::cost_t     right_read,
	input  wire scac_pkg::move_t     move_cost,
	output logic                     valid_s2,
	output scac_pkg::pix_ctrl_t      ctrl_s2,
	output scac_pkg::cost_t          cost
);

	scac_pkg::cost_t   left_above_q;
	scac_pkg::cost_t   center_above_q;
	scac_pkg::cost_t   up;
	scac_pkg::cost_t   right;
	scac_pkg::cost_t   min_cost;
	scac_pkg::cost_t   min_s2;
	scac_pkg::energy_t energy_s2;
	logic [scac_pkg::COST_W:0] sum;
	scac_pkg::cost_t   sat;
	scac_pkg::cost_t   move_ext;

	always_comb begin
		up       = ctrl_s1.has_left ? center_above_q : up_read;
		right    = ctrl_s1.has_right ? right_read : '0;
		min_cost = up;
		if (ctrl_s1.has_left && (left_above_q < min_cost)) begin
			min_cost = left_above_q;
		end
		if (ctrl_s1.has_right && (right < min_cost)) begin
			min_cost = right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_above_q   <= '0;
			center_above_q <= '0;
			valid_s2       <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				left_above_q   <= up;
				center_above_q <= right;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			ctrl_s2   <= ctrl_s1;
			min_s2    <= min_cost;
			energy_s2 <= energy_s1;
		end
	end

	always_comb begin
		sum      = (scac_pkg::COST_W + 1)'(min_s2) + (scac_pkg::COST_W + 1)'(energy_s2);
		sat      = sum[scac_pkg::COST_W] ? scac_pkg::COST_MAX : sum[scac_pkg::COST_W-1:0];
		move_ext = scac_pkg::COST_W'(move_cost);
		if (ctrl_s2.first_row) begin
			cost = scac_pkg::START_COST;
		end else if ((sat > scac_pkg::MID_LOW) && (sat < scac_pkg::MID_HIGH)) begin
			cost = (sat > move_ext) ? (sat - move_ext) : '0;
		end else begin
			cost = sat;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/seam_cost_accumulator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// seam_cost_accumulator: vertical cumulative seam cost
// Streams pixel energies in raster order and returns one cumulative seam
// cost per pixel, keeping the row above in a line buffer.
// ----------------------------------------------------------------------------
// The block takes one pixel request per clock while no stall or hazard holds
// it, and gives one cost per pixel, in order, through stage one, stage two
// and the output register. A pixel reads the row above at acceptance and its
// own cost is written back to the line buffer as it leaves stage two, so the
// first pixel of a row is held back while the pixel just before it, still in
// stage one, is to write entry zero or one (rows of one or two pixels, or a
// frame that starts right after such a column). A result waiting in the
// output register holds the whole pipeline, so no request is taken until that
// result is accepted. The line buffer needs no clearing pass; each row must be
// no wider than the row above it.
module seam_cost_accumulator (
	input  wire                                clk,
	input  wire                                arst_n,
	scac_pixel_if.sink                         pixel,
	scac_result_if.source                      result,
	input  wire                                cfg_write_en,
	input  wire [scac_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [scac_pkg::CFG_DATA_W-1:0]     cfg_data
);

	scac_pkg::row_len_t  row_width_q;
	scac_pkg::move_t     move_cost_q;
	scac_pkg::pix_ctrl_t ctrl_in;
	scac_pkg::pix_ctrl_t ctrl_s1;
	scac_pkg::pix_ctrl_t ctrl_s2;
	scac_pkg::energy_t   energy_s1;
	scac_pkg::cost_t     up_read;
	scac_pkg::cost_t     right_read;
	scac_pkg::cost_t     cost_s2;
	scac_pkg::cost_t     cost_q;
	scac_pkg::col_t      right_addr;
	logic                valid_s1;
	logic                valid_s2;
	logic                res_valid_q;
	logic                end_of_row_q;
	logic                advance;
	logic                hazard;
	logic                accept;
	logic                wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= scac_pkg::ROW_WIDTH_RESET;
			move_cost_q <= scac_pkg::MOVE_COST_RESET;
		end else if (cfg_write_en) begin
			unique case (scac_pkg::cfg_reg_t'(cfg_index))
				scac_pkg::REG_ROW_WIDTH: row_width_q <= cfg_data[scac_pkg::ROW_W-1:0];
				scac_pkg::REG_MOVE_COST: move_cost_q <= cfg_data[scac_pkg::MOVE_W-1:0];
			endcase
		end
	end

	scac_column_ctrl u_column_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.row_width      (row_width_q),
		.start_of_frame (pixel.start_of_frame),
		.accept         (accept),
		.ctrl           (ctrl_in)
	);

	assign right_addr = ctrl_in.col + scac_pkg::COL_W'(1);
	assign advance    = !res_valid_q || result.ready;
	// The pixel in stage one writes its entry too late to be forwarded.
	assign hazard     = valid_s1 && (((ctrl_in.col == '0) && (ctrl_s1.col == '0))
		|| (ctrl_in.has_right && (ctrl_s1.col == right_addr)));
	assign pixel.ready = advance && !hazard;
	assign accept      = pixel.valid && pixel.ready;
	assign wr_en       = valid_s2 && advance;

	scac_line_buffer u_line_buffer (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (ctrl_s2.col),
		.wr_data   (cost_s2),
		.rd_en     (accept),
		.rd_addr_a (ctrl_in.col),
		.rd_addr_b (right_addr),
		.rd_data_a (up_read),
		.rd_data_b (right_read)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1   <= ctrl_in;
			energy_s1 <= pixel.energy;
		end
	end

	scac_cost_unit u_cost_unit (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.ctrl_s1    (ctrl_s1),
		.energy_s1  (energy_s1),
		.up_read    (up_read),
		.right_read (right_read),
		.move_cost  (move_cost_q),
		.valid_s2   (valid_s2),
		.ctrl_s2    (ctrl_s2),
		.cost       (cost_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cost_q       <= cost_s2;
			end_of_row_q <= ctrl_s2.last;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.cum_cost   = cost_q;
	assign result.end_of_row = end_of_row_q;

	ap_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted pixel did not enter the first stage");

	ap_write_is_result: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (res_valid_q && (cost_q == $past(cost_s2))
			&& (end_of_row_q == $past(ctrl_s2.last))))
		else $error("line buffer write and result register disagree");

	ap_no_stage_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && valid_s1) |-> ((ctrl_in.col != '0) || (ctrl_s1.col != '0)))
		else $error("pixel accepted while its line buffer entry is pending");

	ap_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |=> (res_valid_q && $stable(cost_q)
			&& !$past(wr_en)))
		else $error("pipeline moved while the result was stalled");

endmodule
`default_nettype wire

// ----- sim/seam_cost_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seam_cost_checker: cost predictor and result scoreboard
// Watches the pixel, result and register ports of the seam cost accumulator.
// Every accepted pixel request advances a private copy of the line buffer and
// the column state and queues the expected cost. Every accepted result is
// compared field by field against the oldest queued cost.
// ----------------------------------------------------------------------------
module seam_cost_checker (
	input  wire                            clk,
	input  wire                            arst_n,
	scac_pixel_if                          pixel,
	scac_result_if                         result,
	input  wire                            cfg_write_en,
	input  wire [scac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [scac_pkg::CFG_DATA_W-1:0] cfg_data,
	output int unsigned                    pending,
	output int unsigned                    fail_count
);

	typedef struct packed {
		scac_pkg::cost_t cost;
		logic            row_end;
	} cost_rec_t;

	scac_pkg::cost_t    row_above [scac_pkg::MAX_WIDTH];
	cost_rec_t          cost_fifo [$];
	scac_pkg::row_len_t width_reg;
	scac_pkg::move_t    move_reg;
	scac_pkg::col_t     next_col;
	logic               on_first_row;
	scac_pkg::cost_t    up_left;
	scac_pkg::cost_t    up_center;
	int unsigned        failures;

	task automatic predict_cost(input scac_pkg::energy_t energy, input logic sof);
		int unsigned               width;
		int unsigned               col;
		logic                      last;
		scac_pkg::cost_t           up;
		scac_pkg::cost_t           right;
		scac_pkg::cost_t           low;
		scac_pkg::cost_t           cost;
		logic [scac_pkg::COST_W:0] sum;
		cost_rec_t                 rec;
		if (width_reg == 0) width = 1;
		else if (width_reg > scac_pkg::MAX_WIDTH) width = scac_pkg::MAX_WIDTH;
		else width = width_reg;
		if (sof) begin
			next_col     = '0;
			on_first_row = 1'b1;
		end
		col   = next_col;
		last  = (col + 1 >= width);
		up    = (col > 0) ? up_center : row_above[col];
		right = last ? '0 : row_above[col + 1];
		if (on_first_row) begin
			cost = scac_pkg::START_COST;
		end else begin
			low = up;
			if (col > 0 && up_left < low) low = up_left;
			if (!last && right < low) low = right;
			sum  = energy + low;
			cost = sum[scac_pkg::COST_W] ? scac_pkg::COST_MAX
				: sum[scac_pkg::COST_W-1:0];
			if (cost > scac_pkg::MID_LOW && cost < scac_pkg::MID_HIGH)
				cost = (cost > move_reg) ? cost - move_reg : '0;
		end
		up_left          = up;
		up_center        = right;
		row_above[col]   = cost;
		if (last) begin
			next_col     = '0;
			on_first_row = 1'b0;
		end else begin
			next_col = scac_pkg::col_t'(col + 1);
		end
		rec.cost    = cost;
		rec.row_end = last;
		cost_fifo.push_back(rec);
	endtask

	always @(posedge clk or negedge arst_n) begin
		cost_rec_t want;
		if (!arst_n) begin
			width_reg    = scac_pkg::ROW_WIDTH_RESET;
			move_reg     = scac_pkg::MOVE_COST_RESET;
			next_col     = '0;
			on_first_row = 1'b1;
			up_left      = '0;
			up_center    = '0;
			failures     = 0;
			foreach (row_above[i]) row_above[i] = '0;
			cost_fifo.delete();
			pending    <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_write_en) begin
				case (scac_pkg::cfg_reg_t'(cfg_index))
					scac_pkg::REG_ROW_WIDTH: width_reg = cfg_data[scac_pkg::ROW_W-1:0];
					scac_pkg::REG_MOVE_COST: move_reg = cfg_data[scac_pkg::MOVE_W-1:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (cost_fifo.size() == 0) begin
					if (failures < 10)
						$display("unexpected result: cum_cost %h end_of_row %b",
							result.cum_cost, result.end_of_row);
					failures++;
				end else begin
					want = cost_fifo.pop_front();
					if (result.cum_cost !== want.cost
						|| result.end_of_row !== want.row_end) begin
						if (failures < 10)
							$display({"mismatch: cum_cost %h (expected %h) ",
								"end_of_row %b (expected %b)"},
								result.cum_cost, want.cost,
								result.end_of_row, want.row_end);
						failures++;
					end
				end
			end
			if (pixel.valid && pixel.ready)
				predict_cost(pixel.energy, pixel.start_of_frame);
			pending    <= cost_fifo.size();
			fail_count <= failures;
		end
	end
endmodule

// ----- sim/seam_cost_accumulator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seam_cost_accumulator_test: stimulus and verdict for the seam cost block
// Drives pixel energies through directed frames covering the row edges,
// single-column rows, width clamping, narrowing within a row and move cost
// clamping, then one wide frame, one tall saturating column and random
// frames with random idling on both channels. Checking is done by the
// seam_cost_checker instance.
// ----------------------------------------------------------------------------
module seam_cost_accumulator_test;

	localparam int unsigned IDLE_LIMIT   = 1000;
	localparam int unsigned RANDOM_ITEMS = 1300;
	localparam int unsigned WIDE_WIDTH   = 48;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_write_en;
	logic [scac_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [scac_pkg::CFG_DATA_W-1:0] cfg_data;
	int unsigned                     pending;
	int unsigned                     fail_count;
	int unsigned                     idle_cycles = 0;
	int unsigned                     random_count;
	bit                              steady;

	scac_pixel_if  pixel ();
	scac_result_if result ();

	seam_cost_accumulator i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel       (pixel),
		.result      (result),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	seam_cost_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel       (pixel),
		.result      (result),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pending     (pending),
		.fail_count  (fail_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((pixel.valid && pixel.ready) || (result.valid && result.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(input scac_pkg::cfg_reg_t index, input int unsigned value);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= index;
		cfg_data     <= value[scac_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic drain();
		pixel.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic send_pixel(input scac_pkg::energy_t energy, input logic sof);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			pixel.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel.valid          <= 1'b1;
		pixel.energy         <= energy;
		pixel.start_of_frame <= sof;
		do @(posedge clk); while (!pixel.ready);
	endtask

	function automatic scac_pkg::energy_t draw_energy();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return scac_pkg::energy_t'($urandom_range(0, 511));
			3: return scac_pkg::energy_t'($urandom_range(0, 65535));
			default: return scac_pkg::energy_t'($urandom);
		endcase
	endfunction

	function automatic int unsigned draw_width();
		case ($urandom_range(0, 9))
			0: return 0;
			1, 2: return 1;
			3, 4: return $urandom_range(2, 4);
			5, 6, 7: return $urandom_range(5, 16);
			default: return $urandom_range(17, 40);
		endcase
	endfunction

	function automatic int unsigned draw_move_cost();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 16'hFFFF;
			2: return $urandom_range(0, 1023);
			3: return 256;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	// Every line buffer entry that a random width can reach has been written
	// by the wide frame before this runs, so a phase may also continue the
	// current frame at any width.
	task automatic run_phase();
		int unsigned width;
		int unsigned eff;
		int unsigned count;
		logic        new_frame;
		drain();
		steady = ($urandom_range(0, 3) == 0);
		width  = draw_width();
		write_reg(scac_pkg::REG_ROW_WIDTH, width);
		if ($urandom_range(0, 1) != 0) write_reg(scac_pkg::REG_MOVE_COST, draw_move_cost());
		new_frame = ($urandom_range(0, 3) != 0);
		eff       = (width == 0) ? 1 : width;
		count     = $urandom_range(1, 6) * eff;
		if ($urandom_range(0, 2) == 0) count += $urandom_range(0, eff - 1);
		for (int unsigned i = 0; i < count; i++)
			send_pixel(draw_energy(), (i == 0 && new_frame) || $urandom_range(0, 199) == 0);
		random_count += count;
	endtask

	initial begin
		int unsigned stall;
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
		end
	end

	initial begin
		arst_n               <= 1'b0;
		cfg_write_en         <= 1'b0;
		cfg_index            <= scac_pkg::REG_ROW_WIDTH;
		cfg_data             <= '0;
		pixel.valid          <= 1'b0;
		pixel.energy         <= '0;
		pixel.start_of_frame <= 1'b0;
		steady               = 1'b0;
		random_count         = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(scac_pkg::REG_ROW_WIDTH, 3);
		write_reg(scac_pkg::REG_MOVE_COST, 256);
		send_pixel(24'hFFFFFF, 1'b1);
		send_pixel(24'h000000, 1'b0);
		send_pixel(24'h123456, 1'b0);
		send_pixel(24'h000000, 1'b0);
		send_pixel(24'h000080, 1'b0);
		send_pixel(24'hFFFFFF, 1'b0);
		send_pixel(24'h00FE00, 1'b0);
		// A new frame request arrives in the middle of a row.
		send_pixel(24'h000100, 1'b1);
		send_pixel(24'h0000FF, 1'b0);
		send_pixel(24'h00FF00, 1'b0);
		drain();

		write_reg(scac_pkg::REG_ROW_WIDTH, 0);
		write_reg(scac_pkg::REG_MOVE_COST, 16'hFFFF);
		send_pixel(24'h000010, 1'b1);
		send_pixel(24'h000200, 1'b0);
		send_pixel(24'h00FF00, 1'b0);
		send_pixel(24'hFFFFFF, 1'b0);
		drain();

		write_reg(scac_pkg::REG_ROW_WIDTH, 8191);
		write_reg(scac_pkg::REG_MOVE_COST, 0);
		send_pixel(24'h000001, 1'b1);
		send_pixel(24'h000002, 1'b0);
		send_pixel(24'h000003, 1'b0);
		send_pixel(24'h000004, 1'b0);
		drain();
		// The row is cut short by the narrower width.
		write_reg(scac_pkg::REG_ROW_WIDTH, 2);
		send_pixel(24'h000005, 1'b0);
		send_pixel(24'h0000F0, 1'b0);
		send_pixel(24'h000000, 1'b0);
		send_pixel(24'hFFFFFF, 1'b0);
		send_pixel(24'h000300, 1'b0);
		drain();

		// Two rows wider than any random width fill the reachable entries.
		write_reg(scac_pkg::REG_ROW_WIDTH, WIDE_WIDTH);
		write_reg(scac_pkg::REG_MOVE_COST, 256);
		for (int unsigned i = 0; i < 2 * WIDE_WIDTH; i++)
			send_pixel(draw_energy(), i == 0);
		drain();

		// A single column of near-maximum energies runs into saturation.
		write_reg(scac_pkg::REG_ROW_WIDTH, 1);
		for (int unsigned i = 0; i < 300; i++)
			send_pixel(scac_pkg::energy_t'($urandom_range(24'hF00000, 24'hFFFFFF)),
				i == 0);

		while (random_count < RANDOM_ITEMS) run_phase();
		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
